// ===== rtl/core/windowed_path_length_top_assert.svh =====
// Assertion macros shared by the checker of the windowed path length block.
// No dependencies; include by bare file name.
`ifndef WINDOWED_PATH_LENGTH_TOP_ASSERT_SVH
`define WINDOWED_PATH_LENGTH_TOP_ASSERT_SVH

// same-cycle implication under reset
`define WPL_AST_SAME(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under reset
`define WPL_AST_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/wlen_pkg.sv =====
// Package of the windowed path length block: widths, defaults, shared types.
// No dependencies.
package wlen_pkg;

	localparam int MAX_POINTS_DEF = 64;
	localparam int COORD_BITS_DEF = 12;

	localparam int TIME_W    = 32;
	localparam int WIN_W     = 16;
	localparam int LEN_W     = 23;
	localparam int CNT_OUT_W = 7;
	localparam int APB_DW    = 32;
	localparam int APB_AW    = 2;
	localparam int FRAC_SH   = 8;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [WIN_W-1:0]  WINDOW_RESET = 16'd2000;
	localparam logic [LEN_W-1:0]  LEN_MAX      = {LEN_W{1'b1}};
	localparam logic [APB_AW-1:0] ADDR_WINDOW  = 2'd0;

	typedef struct packed {
		logic vld;
		logic busy;
	} sqrt_stat_t;

endpackage

// ===== rtl/core/windowed_path_length_top.sv =====
// Top level of the windowed path length block: APB register, input queue, engine.
// Depends on wlen_pkg, wlen_queue and wlen_engine.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall  x_pos, y_pos, time_ms
//   out      source     out_valid/ out_stall total_length, point_count
//   apb      slave      psel/penable/pready  window_ms at byte address 0
//
// For each item the engine writes the new point, then runs the expiry walk, which
// reads and then tests one ring entry at a time (S_EXP_RD, S_EXP_CHK), then the
// segment walk, which reads one kept entry a cycle through the single RAM read port,
// and then lets the square-root pipeline drain.
// A stalled result beat holds the engine in its last state; two items queue at the input.
// Reset is asynchronous; the ring needs no clearing pass, only the counters reset.
module windowed_path_length_top #(
	parameter int MAX_POINTS = wlen_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = wlen_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [COORD_BITS-1:0]             x_pos,
	input  logic [COORD_BITS-1:0]             y_pos,
	input  logic [wlen_pkg::TIME_W-1:0]       time_ms,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [wlen_pkg::LEN_W-1:0]        total_length,
	output logic [wlen_pkg::CNT_OUT_W-1:0]    point_count,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [wlen_pkg::APB_AW-1:0]       paddr,
	input  logic [wlen_pkg::APB_DW-1:0]       pwdata,
	output logic [wlen_pkg::APB_DW-1:0]       prdata,
	output logic                              pready
);

	localparam int DW = 2 * COORD_BITS + wlen_pkg::TIME_W;

	logic [wlen_pkg::WIN_W-1:0] window_q;
	logic                       q_valid, q_pop;
	logic [DW-1:0]              q_data;

	assign pready = 1'b1;
	assign prdata = (paddr == wlen_pkg::ADDR_WINDOW) ?
			wlen_pkg::APB_DW'(window_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= wlen_pkg::WINDOW_RESET;
		end else if (psel && penable && pwrite && pready) begin
			window_q <= pwdata[wlen_pkg::WIN_W-1:0];
		end
	end

	wlen_queue #(.WIDTH(DW)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (in_valid),
		.push_stall (in_stall),
		.push_data  ({time_ms, y_pos, x_pos}),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_data   (q_data)
	);

	wlen_engine #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_pop        (q_pop),
		.q_x          (q_data[COORD_BITS-1:0]),
		.q_y          (q_data[2*COORD_BITS-1:COORD_BITS]),
		.q_t          (q_data[DW-1:2*COORD_BITS]),
		.window_ms    (window_q),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.total_length (total_length),
		.point_count  (point_count)
	);

endmodule

// ===== rtl/core/wlen_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module wlen_ram #(
	parameter int WIDTH = 56,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/wlen_queue.sv =====
// Front part: two-entry queue that takes input beats and hands them to the engine.
// Depends on wlen_pkg.
module wlen_queue #(
	parameter int WIDTH = 56
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_stall,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PW = $clog2(wlen_pkg::QUEUE_DEPTH);
	localparam int CW = $clog2(wlen_pkg::QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] ent_q [wlen_pkg::QUEUE_DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign push_stall = (cnt_q == CW'(wlen_pkg::QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = ent_q[rd_q];
	assign do_push    = push_valid && !push_stall;
	assign do_pop     = pop && pop_valid;

	function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
		nxt = (p == PW'(wlen_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= nxt(wr_q);
			end
			if (do_pop) begin
				rd_q <= nxt(rd_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= push_data;
		end
	end

endmodule

// ===== rtl/core/wlen_sqrt.sv =====
// Pipelined floor square root, one result bit per stage, one radicand per cycle.
// Depends on wlen_pkg.
module wlen_sqrt #(
	parameter int COORD_BITS = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_vld,
	input  logic [2*(COORD_BITS+5)-1:0]       in_rad,
	output logic [COORD_BITS+4:0]             out_root,
	output wlen_pkg::sqrt_stat_t              stat
);

	localparam int RB   = COORD_BITS + 5;
	localparam int RW   = 2 * RB;
	localparam int REMW = RB + 3;

	logic [REMW-1:0] rem_s  [RB];
	logic [RB-1:0]   root_s [RB];
	logic [RW-1:0]   rad_s  [RB];
	logic [RB-1:0]   vld_s;

	for (genvar g = 0; g < RB; g++) begin : g_stage
		logic [REMW-1:0] rem_i, cand, trial;
		logic [RB-1:0]   root_i;
		logic [RW-1:0]   rad_i;
		logic            vld_i;

		if (g == 0) begin : g_first
			assign rem_i  = '0;
			assign root_i = '0;
			assign rad_i  = in_rad;
			assign vld_i  = in_vld;
		end else begin : g_rest
			assign rem_i  = rem_s[g-1];
			assign root_i = root_s[g-1];
			assign rad_i  = rad_s[g-1];
			assign vld_i  = vld_s[g-1];
		end

		assign cand  = {rem_i[REMW-3:0], rad_i[RW-1 -: 2]};
		assign trial = REMW'({root_i, 2'b01});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else begin
				vld_s[g] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			rad_s[g] <= rad_i << 2;
			if (cand >= trial) begin
				rem_s[g]  <= cand - trial;
				root_s[g] <= {root_i[RB-2:0], 1'b1};
			end else begin
				rem_s[g]  <= cand;
				root_s[g] <= {root_i[RB-2:0], 1'b0};
			end
		end
	end

	assign out_root  = root_s[RB-1];
	assign stat.vld  = vld_s[RB-1];
	assign stat.busy = |vld_s;

endmodule

// ===== rtl/core/wlen_engine.sv =====
// Back part: ring store, expiry walk, segment walk and length accumulation.
// Depends on wlen_pkg, wlen_ram and wlen_sqrt.
module wlen_engine #(
	parameter int MAX_POINTS = wlen_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = wlen_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	output logic                              q_pop,
	input  logic [COORD_BITS-1:0]             q_x,
	input  logic [COORD_BITS-1:0]             q_y,
	input  logic [wlen_pkg::TIME_W-1:0]       q_t,
	input  logic [wlen_pkg::WIN_W-1:0]        window_ms,
	input  logic                              out_stall,
	output logic                              out_valid,
	output logic [wlen_pkg::LEN_W-1:0]        total_length,
	output logic [wlen_pkg::CNT_OUT_W-1:0]    point_count
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int C  = COORD_BITS;
	localparam int RB = COORD_BITS + 5;
	localparam int RW = 2 * RB;
	localparam int TW = wlen_pkg::TIME_W;
	localparam int DW = 2 * C + TW;
	localparam int LW = wlen_pkg::LEN_W;

	typedef enum logic [2:0] {
		S_IDLE, S_WRITE, S_EXP_RD, S_EXP_CHK, S_WALK, S_DRAIN, S_DONE
	} state_t;

	state_t        state_q;
	logic [AW-1:0] head_q, ptr_q;
	logic [CW-1:0] count_q, left_q;
	logic [C-1:0]  cur_x_q, cur_y_q;
	logic [TW-1:0] cur_t_q;

	logic          we;
	logic [AW-1:0] waddr, raddr, slot;
	logic [CW:0]   slot_sum;
	logic [DW-1:0] rdata;
	logic [C-1:0]  rd_x, rd_y;
	logic [TW-1:0] rd_t, age;
	logic          expire, pipe_busy;

	logic          rd_vld_s1, first_q;
	logic [C-1:0]  prev_x_q, prev_y_q;
	logic          seg_vld_s2;
	logic [C-1:0]  dx_s2, dy_s2;
	logic [2*C-1:0] mx, my;
	logic          sq_vld_s3;
	logic [2*C:0]  sq_s3;
	logic [RB-1:0] root;
	wlen_pkg::sqrt_stat_t sq_stat;
	logic [LW-1:0] acc_q;
	logic [LW:0]   acc_sum;

	function automatic logic [AW-1:0] inc_idx(input logic [AW-1:0] i);
		inc_idx = (i == AW'(MAX_POINTS - 1)) ? '0 : i + 1'b1;
	endfunction

	assign slot_sum = (CW+1)'(head_q) + (CW+1)'(count_q);
	assign slot     = (slot_sum >= (CW+1)'(MAX_POINTS)) ?
			AW'(slot_sum - (CW+1)'(MAX_POINTS)) : AW'(slot_sum);

	assign we    = (state_q == S_WRITE);
	assign waddr = slot;
	assign raddr = (state_q == S_WALK) ? ptr_q : head_q;
	assign q_pop = (state_q == S_IDLE) && q_valid;

	wlen_ram #(.WIDTH(DW), .DEPTH(MAX_POINTS)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata ({cur_t_q, cur_y_q, cur_x_q}),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rd_x   = rdata[C-1:0];
	assign rd_y   = rdata[2*C-1:C];
	assign rd_t   = rdata[DW-1:2*C];
	assign age    = cur_t_q - rd_t;
	assign expire = (age > TW'(window_ms)) && (count_q != '0);

	assign pipe_busy = rd_vld_s1 || seg_vld_s2 || sq_vld_s3 || sq_stat.busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= '0;
			count_q      <= '0;
			ptr_q        <= '0;
			left_q       <= '0;
			out_valid    <= 1'b0;
			total_length <= '0;
			point_count  <= '0;
		end else begin
			if (state_q == S_DONE && (!out_valid || !out_stall)) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						if (count_q == CW'(MAX_POINTS)) begin
							head_q  <= inc_idx(head_q);
							count_q <= CW'(MAX_POINTS - 1);
						end
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					count_q <= count_q + 1'b1;
					state_q <= S_EXP_RD;
				end
				S_EXP_RD: begin
					state_q <= S_EXP_CHK;
				end
				S_EXP_CHK: begin
					if (expire) begin
						head_q  <= inc_idx(head_q);
						count_q <= count_q - 1'b1;
						state_q <= S_EXP_RD;
					end else begin
						ptr_q   <= head_q;
						left_q  <= count_q;
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					ptr_q  <= inc_idx(ptr_q);
					left_q <= left_q - 1'b1;
					if (left_q <= CW'(1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!pipe_busy) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid || !out_stall) begin
						total_length <= acc_q;
						point_count  <= wlen_pkg::CNT_OUT_W'(count_q);
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_x_q <= q_x;
			cur_y_q <= q_y;
			cur_t_q <= q_t;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1  <= 1'b0;
			first_q    <= 1'b1;
			seg_vld_s2 <= 1'b0;
			sq_vld_s3  <= 1'b0;
		end else begin
			rd_vld_s1  <= (state_q == S_WALK);
			seg_vld_s2 <= rd_vld_s1 && !first_q;
			sq_vld_s3  <= seg_vld_s2;
			if (rd_vld_s1) begin
				first_q <= 1'b0;
			end else if (state_q != S_WALK) begin
				first_q <= 1'b1;
			end
		end
	end

	assign mx = dx_s2 * dx_s2;
	assign my = dy_s2 * dy_s2;

	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			prev_x_q <= rd_x;
			prev_y_q <= rd_y;
			dx_s2    <= (prev_x_q >= rd_x) ? prev_x_q - rd_x : rd_x - prev_x_q;
			dy_s2    <= (prev_y_q >= rd_y) ? prev_y_q - rd_y : rd_y - prev_y_q;
		end
		sq_s3 <= (2*C+1)'(mx) + (2*C+1)'(my);
	end

	wlen_sqrt #(.COORD_BITS(COORD_BITS)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (sq_vld_s3),
		.in_rad   (RW'({sq_s3, {wlen_pkg::FRAC_SH{1'b0}}})),
		.out_root (root),
		.stat     (sq_stat)
	);

	assign acc_sum = {1'b0, acc_q} + (LW+1)'(root);

	always_ff @(posedge clk) begin
		if (state_q == S_EXP_CHK) begin
			acc_q <= '0;
		end else if (sq_stat.vld) begin
			acc_q <= (acc_sum > (LW+1)'(wlen_pkg::LEN_MAX)) ?
					wlen_pkg::LEN_MAX : acc_sum[LW-1:0];
		end
	end

endmodule

// ===== rtl/core/wlen_checker.sv =====
// Port-level checker of the windowed path length block, bound to the top level.
// Depends on wlen_pkg and windowed_path_length_top_assert.svh.
`include "windowed_path_length_top_assert.svh"

module wlen_checker #(
	parameter int MAX_POINTS = wlen_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = wlen_pkg::COORD_BITS_DEF
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic [COORD_BITS-1:0]             x_pos,
	input logic [COORD_BITS-1:0]             y_pos,
	input logic [wlen_pkg::TIME_W-1:0]       time_ms,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [wlen_pkg::LEN_W-1:0]        total_length,
	input logic [wlen_pkg::CNT_OUT_W-1:0]    point_count,
	input logic                              psel,
	input logic                              penable,
	input logic                              pwrite,
	input logic [wlen_pkg::APB_AW-1:0]       paddr,
	input logic [wlen_pkg::APB_DW-1:0]       pwdata,
	input logic [wlen_pkg::APB_DW-1:0]       prdata,
	input logic                              pready
);

	logic [2:0] pend_q;
	logic       in_beat, out_beat;

	assign in_beat  = in_valid && !in_stall;
	assign out_beat = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_beat && !out_beat) begin
			pend_q <= pend_q + 1'b1;
		end else if (out_beat && !in_beat) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	`WPL_AST_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(total_length) && $stable(point_count), "stalled result beat changed")
	`WPL_AST_SAME(a_no_invent, clk, arst_n, out_valid, pend_q != 3'd0, "result beat without a pending input beat")
	`WPL_AST_SAME(a_pend_bound, clk, arst_n, 1'b1, pend_q <= 3'd4, "more input beats held than the block can store")

	if (MAX_POINTS < 128) begin : g_count_checks
		`WPL_AST_SAME(a_count_nz, clk, arst_n, out_valid, point_count != '0, "result with no kept point")
		`WPL_AST_SAME(a_single_zero, clk, arst_n, out_valid && point_count == 7'd1, total_length == '0, "single point with non-zero length")
	end

endmodule

bind windowed_path_length_top wlen_checker #(
	.MAX_POINTS (MAX_POINTS),
	.COORD_BITS (COORD_BITS)
) u_checker (.*);

// ===== dv/windowed_path_length_top_tb.sv =====
// Self-checking testbench for the windowed path length block: directed and random
// position beats against an in-bench trail predictor, window register over APB.
// Depends on wlen_pkg and windowed_path_length_top.
module windowed_path_length_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wlen_pkg::*;

	localparam int DEPTH = MAX_POINTS_DEF;
	localparam int COORD = COORD_BITS_DEF;
	localparam longint CYCLE_LIMIT = 1_000_000;

	typedef struct packed {
		logic [LEN_W-1:0]     length;
		logic [CNT_OUT_W-1:0] count;
	} path_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [COORD-1:0]     x_pos = '0;
	logic [COORD-1:0]     y_pos = '0;
	logic [TIME_W-1:0]    time_ms = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [LEN_W-1:0]     total_length;
	logic [CNT_OUT_W-1:0] point_count;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [APB_AW-1:0]    paddr = '0;
	logic [APB_DW-1:0]    pwdata = '0;
	logic [APB_DW-1:0]    prdata;
	logic                 pready;

	// trail predictor state
	logic [COORD-1:0]  trail_x [DEPTH];
	logic [COORD-1:0]  trail_y [DEPTH];
	logic [TIME_W-1:0] trail_t [DEPTH];
	int unsigned       trail_oldest = 0;
	int unsigned       trail_kept = 0;
	logic [WIN_W-1:0]  window_setting = WINDOW_RESET;

	path_result_t      pending_paths [$];
	logic [TIME_W-1:0] stamp_cursor = '0;
	int unsigned       src_idle_pct = 0;
	int unsigned       sink_idle_pct = 0;
	int unsigned       sink_hold = 0;
	int unsigned       error_count = 0;
	longint            cycle_count = 0;

	windowed_path_length_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.x_pos(x_pos),
		.y_pos(y_pos),
		.time_ms(time_ms),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.total_length(total_length),
		.point_count(point_count),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic report_mismatch(string what, longint got, longint want);
		$display("MISMATCH at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
		error_count++;
	endtask

	function automatic logic [17:0] root_floor(logic [63:0] v);
		logic [17:0] r;
		logic [17:0] trial;
		r = '0;
		for (int b = 17; b >= 0; b--) begin
			trial = r | (18'd1 << b);
			if (64'(trial) * 64'(trial) <= v)
				r = trial;
		end
		return r;
	endfunction

	function automatic path_result_t track_sample(logic [COORD-1:0] x, logic [COORD-1:0] y,
			logic [TIME_W-1:0] now);
		path_result_t      res;
		int unsigned       slot;
		int unsigned       a;
		int unsigned       b;
		logic [COORD-1:0]  dx;
		logic [COORD-1:0]  dy;
		logic [63:0]       sum;
		logic [63:0]       sq;
		logic [TIME_W-1:0] age;
		if (trail_kept >= DEPTH) begin
			trail_oldest = (trail_oldest + 1) % DEPTH;
			trail_kept = DEPTH - 1;
		end
		slot = (trail_oldest + trail_kept) % DEPTH;
		trail_x[slot] = x;
		trail_y[slot] = y;
		trail_t[slot] = now;
		trail_kept++;
		while (trail_kept > 0) begin
			age = now - trail_t[trail_oldest];
			if (age > TIME_W'(window_setting)) begin
				trail_oldest = (trail_oldest + 1) % DEPTH;
				trail_kept--;
			end else begin
				break;
			end
		end
		sum = '0;
		for (int i = 0; i + 1 < trail_kept; i++) begin
			a = (trail_oldest + i) % DEPTH;
			b = (trail_oldest + i + 1) % DEPTH;
			dx = (trail_x[a] >= trail_x[b]) ? trail_x[a] - trail_x[b] : trail_x[b] - trail_x[a];
			dy = (trail_y[a] >= trail_y[b]) ? trail_y[a] - trail_y[b] : trail_y[b] - trail_y[a];
			sq = (64'(dx) * 64'(dx) + 64'(dy) * 64'(dy)) << 8;
			sum += 64'(root_floor(sq));
			if (sum > 64'(LEN_MAX))
				sum = 64'(LEN_MAX);
		end
		res.length = sum[LEN_W-1:0];
		res.count = CNT_OUT_W'(trail_kept);
		return res;
	endfunction

	// mostly advancing stamps, some on the window edge, some backwards, some anywhere
	function automatic logic [TIME_W-1:0] next_stamp(int unsigned step_max);
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 80)
			stamp_cursor += $urandom_range(0, step_max);
		else if (pick < 88)
			stamp_cursor += TIME_W'(window_setting) + $urandom_range(0, 1);
		else if (pick < 94)
			stamp_cursor -= $urandom_range(1, 5000);
		else
			stamp_cursor = $urandom();
		return stamp_cursor;
	endfunction

	function automatic logic [COORD-1:0] pick_coord();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return '1;
		return COORD'($urandom_range(0, (1 << COORD) - 1));
	endfunction

	always @(posedge clk) begin
		if (!arst_n || sink_idle_pct == 0) begin
			out_stall <= 1'b0;
			sink_hold = 0;
		end else if (sink_hold > 0) begin
			sink_hold--;
			if (sink_hold == 0)
				out_stall <= 1'b0;
		end else if ($urandom_range(0, 99) < sink_idle_pct) begin
			out_stall <= 1'b1;
			sink_hold = $urandom_range(1, 17);
		end
	end

	always @(posedge clk) begin
		path_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_paths.size() == 0) begin
				report_mismatch("unexpected beat, total_length", total_length, 0);
			end else begin
				want = pending_paths.pop_front();
				if (total_length !== want.length)
					report_mismatch("total_length", total_length, want.length);
				if (point_count !== want.count)
					report_mismatch("point_count", point_count, want.count);
			end
		end
	end

	task automatic send_sample(logic [COORD-1:0] x, logic [COORD-1:0] y, logic [TIME_W-1:0] t);
		in_valid <= 1'b1;
		x_pos <= x;
		y_pos <= y;
		time_ms <= t;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_paths.push_back(track_sample(x, y, t));
		if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_paths.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic apb_access(logic wr, logic [APB_DW-1:0] data, output logic [APB_DW-1:0] rd);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= ADDR_WINDOW;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_window(logic [WIN_W-1:0] want);
		logic [APB_DW-1:0] rd;
		apb_access(1'b0, '0, rd);
		if (rd[WIN_W-1:0] !== want)
			report_mismatch("window_ms readback", rd[WIN_W-1:0], want);
	endtask

	// upper data bits are noise; only the low half lands in the register
	task automatic set_window(logic [WIN_W-1:0] w);
		logic [APB_DW-1:0] word;
		logic [APB_DW-1:0] rd;
		drain_results();
		word = $urandom();
		word[WIN_W-1:0] = w;
		apb_access(1'b1, word, rd);
		window_setting = w;
		check_window(w);
	endtask

	task automatic test_register_reset();
		check_window(WINDOW_RESET);
	endtask

	task automatic test_directed();
		logic [TIME_W-1:0] t0;
		t0 = 32'hFFFF_FC00;
		src_idle_pct = 20;
		sink_idle_pct = 20;
		send_sample('0, '0, t0);
		send_sample('1, '1, t0 + 1);
		send_sample('1, '0, t0 + 2);
		send_sample('0, '1, t0 + 3);
		send_sample('0, '0, t0 + 3);
		// wraps past zero; age exactly the window is kept, one more is dropped
		send_sample(12'd3, 12'd4, t0 + 2003);
		send_sample(12'd7, 12'd1, t0 + 1993);
		send_sample(12'd100, 12'd200, t0 - 2997);
		send_sample(12'd2048, 12'd1024, t0 - 2990);
		set_window('0);
		send_sample(12'd1, 12'd1, 32'h0000_1000);
		send_sample(12'd2, 12'd2, 32'h0000_1000);
		send_sample(12'd5, 12'd5, 32'h0000_1001);
		send_sample(12'hAAA, 12'h555, 32'h0000_1001);
		set_window('1);
		send_sample(12'h555, 12'hAAA, 32'h8000_0000);
		send_sample('1, '0, 32'h8000_FFFF);
		send_sample('0, '1, 32'h8001_0000);
		send_sample(12'd10, 12'd10, 32'h7FFF_FFFF);
		stamp_cursor = 32'h8001_0000;
		drain_results();
	endtask

	task automatic test_full_ring();
		set_window('1);
		src_idle_pct = 10;
		sink_idle_pct = 10;
		for (int i = 0; i < 90; i++) begin
			stamp_cursor += $urandom_range(0, 5);
			send_sample(pick_coord(), pick_coord(), stamp_cursor);
		end
		drain_results();
	endtask

	task automatic test_random_windows();
		logic [WIN_W-1:0] settings [5];
		settings[0] = '0;
		settings[1] = 16'd1;
		settings[2] = '1;
		settings[3] = WIN_W'($urandom_range(2, 65534));
		settings[4] = WIN_W'($urandom_range(2, 4000));
		for (int p = 0; p < 5; p++) begin
			set_window(settings[p]);
			src_idle_pct = (p % 2 == 0) ? 25 : 0;
			sink_idle_pct = (p == 3) ? 0 : 25;
			for (int i = 0; i < 120; i++)
				send_sample(pick_coord(), pick_coord(), next_stamp(settings[p] / 24 + 1));
		end
		drain_results();
	endtask

	task automatic test_no_idling();
		set_window(WINDOW_RESET);
		src_idle_pct = 0;
		sink_idle_pct = 0;
		for (int i = 0; i < 100; i++)
			send_sample(pick_coord(), pick_coord(), next_stamp(WINDOW_RESET / 24 + 1));
		drain_results();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_reset();
		test_directed();
		test_full_ring();
		test_random_windows();
		test_no_idling();
		repeat (300) @(posedge clk);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/wlen_pkg.sv
rtl/core/wlen_ram.sv
rtl/core/wlen_queue.sv
rtl/core/wlen_sqrt.sv
rtl/core/wlen_engine.sv
rtl/core/windowed_path_length_top.sv
rtl/core/wlen_checker.sv
dv/windowed_path_length_top_tb.sv
